// ----- rtl/bpa_pkg.sv -----
// Package: shared constants, payload types, control structs and helpers of the block pool allocator.
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int NUM_BLOCKS  = 64;
    localparam int BLOCK_BYTES = 8192;
    localparam int ALIGN_BYTES = 8;
    localparam int STAMP_BITS  = 48;

    localparam int NB_W    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
    localparam int FILL_W  = $clog2(BLOCK_BYTES + 1);
    localparam int BYTES_W = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);
    // Rounded request sizes stay below 65536 + ALIGN_BYTES.
    localparam int XW      = $clog2(65536 + ALIGN_BYTES);
    localparam int ALIGN_W = $clog2(ALIGN_BYTES + 1);
    localparam int RECIP_W = XW + 1;
    localparam int RECIP   = (1 << XW) / ALIGN_BYTES;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_RESET   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_INVALID   = 2'd1,
        STS_TOO_LARGE = 2'd2,
        STS_EXHAUSTED = 2'd3
    } status_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] request_bytes;
        logic [47:0] time_now;
        logic [47:0] age_limit;
    } bpa_in_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  block_index;
        logic [12:0] byte_offset;
        logic [6:0]  blocks_freed;
        logic [6:0]  live_blocks;
        logic [19:0] live_bytes;
        logic [31:0] alloc_count;
        logic [31:0] failure_count;
        logic [31:0] release_count;
    } bpa_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_FIND,
        ST_WALK,
        ST_DRAIN,
        ST_COMMIT
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic calc;
        logic find;
        logic walk;
        logic commit;
    } bpa_cmd_t;

    typedef struct packed {
        logic walk_last;
        logic out_busy;
    } bpa_stat_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ----- rtl/bpa_free_finder.sv -----
// Two-stage registered search for the lowest-numbered inactive block.
`timescale 1ns / 1ps

module bpa_free_finder import bpa_pkg::*; (
    input  logic                  aclk,
    input  logic [NUM_BLOCKS-1:0] active,
    output logic                  found,
    output logic [NB_W-1:0]       idx
);

    localparam int GRP_SIZE = 8;
    localparam int NGRP     = (NUM_BLOCKS + GRP_SIZE - 1) / GRP_SIZE;

    logic [NGRP*GRP_SIZE-1:0] act_pad;
    logic [NGRP-1:0]          grp_free_next;
    logic [NGRP-1:0]          grp_free_reg;
    logic [2:0]               grp_idx_next [NGRP];
    logic [2:0]               grp_idx_reg  [NGRP];
    logic                     found_next;
    logic                     found_reg;
    logic [NB_W-1:0]          idx_next;
    logic [NB_W-1:0]          idx_reg;

    // Blocks past the end of the pool look permanently active.
    always_comb begin
        act_pad = '1;
        act_pad[NUM_BLOCKS-1:0] = active;
        for (int g = 0; g < NGRP; g++) begin
            grp_free_next[g] = 1'b0;
            grp_idx_next[g]  = '0;
            for (int j = GRP_SIZE - 1; j >= 0; j--) begin
                if (!act_pad[g*GRP_SIZE + j]) begin
                    grp_free_next[g] = 1'b1;
                    grp_idx_next[g]  = 3'(j);
                end
            end
        end
    end

    always_comb begin
        found_next = 1'b0;
        idx_next   = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_free_reg[g]) begin
                found_next = 1'b1;
                idx_next   = NB_W'(g * GRP_SIZE) + NB_W'(grp_idx_reg[g]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_free_reg <= grp_free_next;
        grp_idx_reg  <= grp_idx_next;
        found_reg    <= found_next;
        idx_reg      <= idx_next;
    end

    assign found = found_reg;
    assign idx   = idx_reg;

endmodule

// ----- rtl/bpa_ctrl.sv -----
// Controller state machine sequencing allocate, release and reset operations.
`timescale 1ns / 1ps

module bpa_ctrl import bpa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  op_t       s_op,
    output logic      s_ready,
    input  bpa_stat_t stat,
    output bpa_cmd_t  cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_op == OP_RELEASE) ? ST_WALK : ST_CALC;
                end
            end
            ST_CALC:   state_next = ST_FIND;
            ST_FIND:   state_next = ST_COMMIT;
            ST_WALK: begin
                if (stat.walk_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_COMMIT;
            ST_COMMIT: begin
                if (!stat.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_CALC:   cmd.calc   = 1'b1;
            ST_FIND:   cmd.find   = 1'b1;
            ST_WALK:   cmd.walk   = 1'b1;
            ST_DRAIN:  cmd        = '0;
            ST_COMMIT: cmd.commit = !stat.out_busy;
            default:   cmd        = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/bpa_datapath.sv -----
// Datapath: block tables, size rounding, stamp walk, statistics and result register.
`timescale 1ns / 1ps

module bpa_datapath import bpa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  bpa_cmd_t  cmd,
    output bpa_stat_t stat,
    input  bpa_in_t   s_data,
    input  logic      m_ready,
    output logic      m_valid,
    output bpa_out_t  m_data
);

    // Block tables: active bits in flip-flops, fill and stamp in memories.
    logic [FILL_W-1:0]     fill_mem  [NUM_BLOCKS];
    logic [STAMP_BITS-1:0] stamp_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] active_reg;

    bpa_in_t               in_reg;
    logic [XW-1:0]         x_reg;
    logic [XW-1:0]         q_est_reg;
    logic [XW-1:0]         need_reg;
    logic                  fill_valid_reg;
    logic [NB_W-1:0]       fill_idx_reg;
    logic [FILL_W-1:0]     fill_level_reg;
    logic [CNT_W-1:0]      active_total_reg;
    logic [BYTES_W-1:0]    bytes_total_reg;
    logic [31:0]           success_cnt_reg;
    logic [31:0]           fail_cnt_reg;
    logic [31:0]           reclaim_cnt_reg;
    logic [NB_W-1:0]       walk_cnt_reg;
    logic                  chk_valid_reg;
    logic [NB_W-1:0]       chk_idx_reg;
    logic [FILL_W-1:0]     fill_rd_reg;
    logic [STAMP_BITS-1:0] stamp_rd_reg;
    logic [CNT_W-1:0]      freed_cnt_reg;
    logic                  m_valid_reg;
    bpa_out_t              m_data_reg;

    logic                  free_found;
    logic [NB_W-1:0]       free_idx;

    logic [XW-1:0]             x_next;
    logic [XW+RECIP_W-1:0]     recip_prod;
    logic [XW+ALIGN_W-1:0]     need_est;
    logic [XW+ALIGN_W-1:0]     need_rem;
    logic [XW+ALIGN_W-1:0]     need_fix;

    logic                  req_zero;
    logic                  too_large;
    logic                  need_new;
    logic                  alloc_ok;
    logic [NB_W-1:0]       slot;
    logic [FILL_W-1:0]     off;
    logic [FILL_W-1:0]     new_level;
    logic                  chk_hit;
    logic [STAMP_BITS-1:0] lim;
    logic [CNT_W-1:0]      freed_out;
    logic [CNT_W-1:0]      active_total_next;
    logic [BYTES_W-1:0]    bytes_total_next;
    logic [31:0]           success_next;
    logic [31:0]           fail_next;
    logic [31:0]           reclaim_next;
    status_t               status_next;
    bpa_out_t              rsp_next;

    bpa_free_finder u_finder (
        .aclk   (aclk),
        .active (active_reg),
        .found  (free_found),
        .idx    (free_idx)
    );

    // Rounding up to the alignment: reciprocal estimate, then one correction.
    always_comb begin
        x_next     = XW'(in_reg.request_bytes) + XW'(ALIGN_BYTES - 1);
        recip_prod = (XW+RECIP_W)'(x_next) * (XW+RECIP_W)'(RECIP);
        need_est   = (XW+ALIGN_W)'(q_est_reg) * (XW+ALIGN_W)'(ALIGN_BYTES);
        need_rem   = (XW+ALIGN_W)'(x_reg) - need_est;
        need_fix   = (need_rem >= (XW+ALIGN_W)'(ALIGN_BYTES)) ?
                     need_est + (XW+ALIGN_W)'(ALIGN_BYTES) : need_est;
    end

    // Allocation decision, evaluated in the commit cycle.
    always_comb begin
        req_zero  = (in_reg.request_bytes == '0);
        too_large = (need_reg > XW'(BLOCK_BYTES));
        need_new  = !fill_valid_reg ||
                    ((XW+1)'(fill_level_reg) + (XW+1)'(need_reg) > (XW+1)'(BLOCK_BYTES));
        alloc_ok  = (in_reg.op == OP_ALLOC) && !req_zero && !too_large &&
                    (!need_new || free_found);
        slot      = need_new ? free_idx : fill_idx_reg;
        off       = need_new ? '0 : fill_level_reg;
        new_level = off + FILL_W'(need_reg);
    end

    // Stamp walk check on the registered memory read data.
    always_comb begin
        lim     = STAMP_BITS'(in_reg.age_limit);
        chk_hit = chk_valid_reg && active_reg[chk_idx_reg] &&
                  !(fill_valid_reg && (chk_idx_reg == fill_idx_reg)) &&
                  (stamp_rd_reg < lim);
    end

    always_comb begin
        status_next       = STS_OK;
        freed_out         = '0;
        active_total_next = active_total_reg;
        bytes_total_next  = bytes_total_reg;
        success_next      = success_cnt_reg;
        fail_next         = fail_cnt_reg;
        reclaim_next      = reclaim_cnt_reg;
        unique case (in_reg.op)
            OP_ALLOC: begin
                priority if (req_zero) begin
                    status_next = STS_INVALID;
                end else if (too_large) begin
                    status_next = STS_TOO_LARGE;
                    fail_next   = sat_add32(fail_cnt_reg, 32'd1);
                end else if (!alloc_ok) begin
                    status_next = STS_EXHAUSTED;
                    fail_next   = sat_add32(fail_cnt_reg, 32'd1);
                end else begin
                    if (need_new) begin
                        active_total_next = active_total_reg + CNT_W'(1);
                    end
                    bytes_total_next = bytes_total_reg + BYTES_W'(need_reg);
                    success_next     = sat_add32(success_cnt_reg, 32'd1);
                end
            end
            OP_RELEASE: begin
                freed_out    = freed_cnt_reg;
                reclaim_next = sat_add32(reclaim_cnt_reg, 32'(freed_cnt_reg));
            end
            OP_RESET: begin
                freed_out         = active_total_reg;
                active_total_next = '0;
                bytes_total_next  = '0;
                reclaim_next      = sat_add32(reclaim_cnt_reg, 32'd1);
            end
            OP_NONE: begin
                status_next = STS_OK;
            end
            default: begin
                status_next = STS_OK;
            end
        endcase

        rsp_next.status        = status_next;
        rsp_next.block_index   = alloc_ok ? 6'(slot) : '0;
        rsp_next.byte_offset   = alloc_ok ? 13'(off) : '0;
        rsp_next.blocks_freed  = 7'(freed_out);
        rsp_next.live_blocks   = 7'(active_total_next);
        rsp_next.live_bytes    = 20'(bytes_total_next);
        rsp_next.alloc_count   = success_next;
        rsp_next.failure_count = fail_next;
        rsp_next.release_count = reclaim_next;
    end

    // Memories: one write port for allocations, one registered read port for the walk.
    always_ff @(posedge aclk) begin
        if (cmd.commit && alloc_ok) begin
            fill_mem[slot]  <= new_level;
            stamp_mem[slot] <= STAMP_BITS'(in_reg.time_now);
        end
        if (cmd.walk) begin
            fill_rd_reg  <= fill_mem[walk_cnt_reg];
            stamp_rd_reg <= stamp_mem[walk_cnt_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.calc) begin
            x_reg     <= x_next;
            q_est_reg <= XW'(recip_prod >> XW);
        end
        if (cmd.find) begin
            need_reg <= XW'(need_fix);
        end
        chk_idx_reg <= walk_cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg       <= '0;
            fill_valid_reg   <= 1'b0;
            fill_idx_reg     <= '0;
            fill_level_reg   <= '0;
            active_total_reg <= '0;
            bytes_total_reg  <= '0;
            success_cnt_reg  <= '0;
            fail_cnt_reg     <= '0;
            reclaim_cnt_reg  <= '0;
            walk_cnt_reg     <= '0;
            chk_valid_reg    <= 1'b0;
            freed_cnt_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            chk_valid_reg <= cmd.walk;
            if (cmd.capture) begin
                walk_cnt_reg  <= '0;
                freed_cnt_reg <= '0;
            end else if (cmd.walk) begin
                walk_cnt_reg <= walk_cnt_reg + NB_W'(1);
            end

            if (cmd.commit) begin
                active_total_reg <= active_total_next;
                bytes_total_reg  <= bytes_total_next;
                success_cnt_reg  <= success_next;
                fail_cnt_reg     <= fail_next;
                reclaim_cnt_reg  <= reclaim_next;
                if (in_reg.op == OP_RESET) begin
                    active_reg     <= '0;
                    fill_valid_reg <= 1'b0;
                    fill_idx_reg   <= '0;
                    fill_level_reg <= '0;
                end else if (alloc_ok) begin
                    active_reg[slot] <= 1'b1;
                    fill_valid_reg   <= 1'b1;
                    fill_idx_reg     <= slot;
                    fill_level_reg   <= new_level;
                end
            end else if (chk_hit) begin
                active_reg[chk_idx_reg] <= 1'b0;
                active_total_reg        <= active_total_reg - CNT_W'(1);
                bytes_total_reg         <= bytes_total_reg - BYTES_W'(fill_rd_reg);
                freed_cnt_reg           <= freed_cnt_reg + CNT_W'(1);
            end

            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_data_reg <= rsp_next;
        end
    end

    assign stat.walk_last = (walk_cnt_reg == NB_W'(NUM_BLOCKS - 1));
    assign stat.out_busy  = m_valid_reg && !m_ready;
    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;

    // The running block count must always agree with the active bits.
    a_active_count: assert property (@(posedge aclk) disable iff (!aresetn)
        active_total_reg == CNT_W'($countones(active_reg)))
        else $error("active block count disagrees with active bits");

    a_fill_active: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_valid_reg |-> active_reg[fill_idx_reg])
        else $error("current fill block is not active");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_valid_reg |-> (fill_level_reg <= FILL_W'(BLOCK_BYTES)))
        else $error("fill level beyond block size");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.commit))
        else $error("result raised without a commit");

endmodule

// ----- rtl/block_pool_arena_allocator_unit.sv -----
// Top level of the block pool bump allocator: controller and datapath.
`timescale 1ns / 1ps

// Usage
// A request transfer on s_valid/s_ready carries one operation in s_data:
// allocate, release blocks older than a limit, reset the pool, or the unused
// code, which only reports the statistics. Every request gives exactly one
// result transfer on m_valid/m_ready, in request order.
// Allocate, reset and the unused code pass through the idle (capture), calc,
// find and commit states: the request is captured, the size is rounded to
// the alignment (a reciprocal multiply and one correction), and the commit
// state places the allocation and loads the result register. A release walks
// the stamp memory through its single read port, one block per cycle, then
// drains the last read and commits. The lowest free block comes from a
// two-stage registered search that tracks the active bits continuously.
// s_ready is high only while the controller is idle; a result still waiting
// in the output register does not stop the next request being taken, but
// the following commit holds until that result has been transferred.
// After aresetn every block is inactive, there is no fill block and all
// counters read zero; no clearing pass is needed.

module block_pool_arena_allocator_unit import bpa_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  bpa_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output bpa_out_t m_data
);

    bpa_cmd_t  cmd;
    bpa_stat_t stat;

    bpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bpa_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule
